// ===== hw/rtl/bd3_pkg.sv =====
// Shared types and constants for the 3x3 binary dilation core.
// No dependencies; imported by the window cell, the core and the testbench.
package bd3_pkg;

  // Widths of the configuration fields and of the configuration port.
  localparam int IMAGE_WIDTH_W  = 11;
  localparam int IMAGE_HEIGHT_W = 13;
  localparam int CFG_DATA_W     = 13;
  localparam int CFG_IDX_W      = 2;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  // One window column: bit 0 top row, bit 1 middle row, bit 2 bottom row.
  typedef logic [2:0] col_t;

  // Control shared by all window cells.
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/bd3_line_store.sv =====
// Line store memory for the dilation core: one write and one registered read per cycle.
// A write to the address being read is forwarded to the read register.
// Depends on nothing.
module bd3_line_store #(
  parameter int DEPTH = 1024,
  parameter int DW    = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DW-1:0]            wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DW-1:0]            rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read with write-to-read forwarding.
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/bd3_window_cell.sv =====
// One column cell of the 3x3 window; cells form a chain that shifts left per transaction.
// Depends on bd3_pkg.
module bd3_window_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bd3_pkg::cell_ctrl_t ctrl_i,
  input  bd3_pkg::col_t     col_i,
  output bd3_pkg::col_t     col_o
);
  import bd3_pkg::*;

  col_t col_q;

  // Column register: cleared on a stream restart, loaded from the neighbor on a shift.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (ctrl_i.clear) begin
      col_q <= '0;
    end else if (ctrl_i.shift) begin
      col_q <= col_i;
    end
  end

  assign col_o = col_q;

endmodule

// ===== hw/rtl/binary_dilation_3x3_core.sv =====
// 3x3 binary dilation core: top level, counters, output register.
// Depends on bd3_pkg, bd3_line_store and bd3_window_cell.
// Throughput: one item per cycle while the output is not held off, set by the line store
// read-modify-write, which prefetches the next column and forwards a same-column write.
// The result for pixel (r, c) is registered when the item one row and one pixel later in the
// stream is accepted, and is offered on the output in the next cycle.
// Reset clears counters, window and output valid; line store contents are not cleared.
module binary_dilation_3x3_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write channel.
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bd3_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bd3_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // Input stream.
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [7:0]                      s_axis_tdata_i,  // [0] pixel_in, [7:1] zero
  input  logic                            s_axis_tuser_i,  // [0] operation
  // Output stream.
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [7:0]                      m_axis_tdata_o,  // [0] pixel_out, [7:1] zero
  output logic                            m_axis_tlast_o,  // row_end
  output logic                            m_axis_tuser_o   // [0] image_end
);
  import bd3_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RESET_WIDTH  = (64 > MAX_WIDTH) ? MAX_WIDTH : 64;
  localparam int RESET_HEIGHT = (64 > MAX_HEIGHT) ? MAX_HEIGHT : 64;

  // Registers.
  logic [WW-1:0] width_q, width_d;
  logic [HW-1:0] height_q, height_d;
  logic [CW-1:0] in_col_q, in_col_d;
  logic [1:0]    in_row_q, in_row_d;
  logic [CW-1:0] out_col_q, out_col_d;
  logic [RW-1:0] out_row_q, out_row_d;
  logic          out_valid_q, out_valid_d;
  logic          out_pix_q, out_pix_d;
  logic          out_row_end_q, out_row_end_d;
  logic          out_img_end_q, out_img_end_d;

  // Datapath signals.
  logic                  cfg_acc, in_acc, restart, pix, emit, last_col, last_row, last;
  logic [1:0]            ls_rdata, ls_wdata;
  logic [WW-1:0]         in_col_inc, out_col_inc;
  logic [HW-1:0]         out_row_inc;
  logic [IMAGE_WIDTH_W-1:0]  width_raw;
  logic [IMAGE_HEIGHT_W-1:0] height_raw;
  col_t                  vec, right_c, mid_c, left_c;
  logic [8:0]            win_nxt, keep;
  cell_ctrl_t            cell_ctrl;

  assign cfg_ready_o     = 1'b1;
  assign cfg_acc         = cfg_valid_i && cfg_ready_o;
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // Column vector: older stored row on top, newer row in the middle, input at the bottom.
  assign pix      = s_axis_tuser_i ? 1'b0 : s_axis_tdata_i[0];
  assign vec      = {pix, ls_rdata[1], ls_rdata[0]};
  assign ls_wdata = {pix, ls_rdata[1]};

  bd3_line_store #(
    .DEPTH(MAX_WIDTH),
    .DW   (2)
  ) u_line_store (
    .clk_i  (clk_i),
    .we_i   (in_acc),
    .waddr_i(in_col_q),
    .wdata_i(ls_wdata),
    .raddr_i(in_col_d),
    .rdata_o(ls_rdata)
  );

  // Window chain: the newest column enters on the right and moves left.
  assign cell_ctrl.shift = in_acc;
  assign cell_ctrl.clear = restart;

  bd3_window_cell u_cell_right (
    .clk_i (clk_i), .rst_ni(rst_ni), .ctrl_i(cell_ctrl), .col_i(vec), .col_o(right_c)
  );
  bd3_window_cell u_cell_mid (
    .clk_i (clk_i), .rst_ni(rst_ni), .ctrl_i(cell_ctrl), .col_i(right_c), .col_o(mid_c)
  );
  bd3_window_cell u_cell_left (
    .clk_i (clk_i), .rst_ni(rst_ni), .ctrl_i(cell_ctrl), .col_i(mid_c), .col_o(left_c)
  );

  // Position, configuration and result logic.
  always_comb begin
    width_raw   = cfg_data_i[IMAGE_WIDTH_W-1:0];
    height_raw  = cfg_data_i[IMAGE_HEIGHT_W-1:0];
    in_col_inc  = WW'(in_col_q) + 1'b1;
    out_col_inc = WW'(out_col_q) + 1'b1;
    out_row_inc = HW'(out_row_q) + 1'b1;
    win_nxt     = {vec, right_c, mid_c};

    emit     = (in_row_q >= 2'd2) || ((in_row_q == 2'd1) && (in_col_q != '0));
    last_col = out_col_inc >= width_q;
    last_row = out_row_inc >= height_q;
    last     = last_col && last_row;

    // Mask window positions that fall outside the image.
    keep = 9'h1FF;
    if (out_col_q == '0) keep = keep & ~9'h007;
    if (last_col)        keep = keep & ~9'h1C0;
    if (out_row_q == '0) keep = keep & ~9'h049;
    if (last_row)        keep = keep & ~9'h124;

    width_d       = width_q;
    height_d      = height_q;
    in_col_d      = in_col_q;
    in_row_d      = in_row_q;
    out_col_d     = out_col_q;
    out_row_d     = out_row_q;
    out_valid_d   = out_valid_q && !m_axis_tready_i;
    out_pix_d     = out_pix_q;
    out_row_end_d = out_row_end_q;
    out_img_end_d = out_img_end_q;
    restart       = 1'b0;

    // Writes to the size registers clamp the value and restart the stream.
    if (cfg_acc) begin
      unique case (cfg_index_i)
        REG_IMAGE_WIDTH: begin
          restart = 1'b1;
          if (width_raw == '0) begin
            width_d = WW'(1);
          end else if (32'(width_raw) > 32'(MAX_WIDTH)) begin
            width_d = WW'(MAX_WIDTH);
          end else begin
            width_d = WW'(width_raw);
          end
        end
        REG_IMAGE_HEIGHT: begin
          restart = 1'b1;
          if (height_raw == '0) begin
            height_d = HW'(1);
          end else if (32'(height_raw) > 32'(MAX_HEIGHT)) begin
            height_d = HW'(MAX_HEIGHT);
          end else begin
            height_d = HW'(height_raw);
          end
        end
        default: begin
          restart = 1'b0;
        end
      endcase
    end

    // Input transaction: advance the input position and emit a result when one is due.
    if (in_acc) begin
      if (in_col_inc >= width_q) begin
        in_col_d = '0;
        if (in_row_q != 2'd2) in_row_d = in_row_q + 2'd1;
      end else begin
        in_col_d = in_col_inc[CW-1:0];
      end
      if (emit) begin
        out_valid_d   = 1'b1;
        out_pix_d     = (win_nxt & keep) != '0;
        out_row_end_d = last_col;
        out_img_end_d = last;
        if (last) begin
          restart = 1'b1;
        end else if (last_col) begin
          out_col_d = '0;
          out_row_d = out_row_inc[RW-1:0];
        end else begin
          out_col_d = out_col_inc[CW-1:0];
        end
      end
    end

    if (restart) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
    end
    if (cfg_acc && restart) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= WW'(RESET_WIDTH);
      height_q    <= HW'(RESET_HEIGHT);
      in_col_q    <= '0;
      in_row_q    <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      width_q     <= width_d;
      height_q    <= height_d;
      in_col_q    <= in_col_d;
      in_row_q    <= in_row_d;
      out_col_q   <= out_col_d;
      out_row_q   <= out_row_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    out_pix_q     <= out_pix_d;
    out_row_end_q <= out_row_end_d;
    out_img_end_q <= out_img_end_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'b0, out_pix_q};
  assign m_axis_tlast_o  = out_row_end_q;
  assign m_axis_tuser_o  = out_img_end_q;

  // The end of an image is always the end of a row.
  a_img_end_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tlast_o)
    else $error("image end without row end");

  // Configured sizes stay in range.
  a_size_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (width_q != '0) && (32'(width_q) <= 32'(MAX_WIDTH)) &&
    (height_q != '0) && (32'(height_q) <= 32'(MAX_HEIGHT)))
    else $error("image size register out of range");

  // Input column stays inside the row.
  a_in_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    WW'(in_col_q) < width_q)
    else $error("input column beyond image width");

  // The saturating row counter never reaches its unused code.
  a_in_row_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_row_q != 2'd3)
    else $error("input row counter overflow");

  // Finishing an image restarts all positions.
  a_last_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && emit && last |=> (in_col_q == '0) && (in_row_q == '0) &&
    (out_col_q == '0) && (out_row_q == '0))
    else $error("positions not restarted after image end");

endmodule

// ===== bench/tb_binary_dilation_3x3_core.sv =====
// Self-checking testbench for binary_dilation_3x3_core: directed rows, then random images.
// Depends on bd3_pkg and the core; predicts every result and compares it field by field.
module tb_binary_dilation_3x3_core;
  timeunit 1ns;
  timeprecision 1ps;

  import bd3_pkg::*;

  localparam int MAX_W         = 1024;
  localparam int MAX_H         = 4096;
  localparam int RESET_CYCLES  = 7;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 300;
  localparam int HOLD_AFTER    = 100;
  localparam int RANDOM_ITEMS  = 500;
  localparam int MAX_PRINTED   = 50;
  localparam int BIG_RUN       = 40;

  // Indexes that decode to no register; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  // Window masks: bits 2:0 are the left column, each column is top, middle, bottom.
  localparam logic [8:0] LEFT_COL   = 9'h007;
  localparam logic [8:0] RIGHT_COL  = 9'h1C0;
  localparam logic [8:0] TOP_ROW    = 9'h049;
  localparam logic [8:0] BOTTOM_ROW = 9'h124;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_PAD   = 1'b1
  } item_op_e;

  typedef struct packed {
    logic pixel;
    logic row_end;
    logic image_end;
  } dilated_px_t;

  // Results that can be typed in directly.
  localparam dilated_px_t BLACK_INTERIOR = 3'b100;
  localparam dilated_px_t BLACK_LAST     = 3'b111;
  localparam dilated_px_t WHITE_LAST     = 3'b011;

  // One row of the directed stimulus: a register write or a run of items.
  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    item_op_e              op;
    logic                  pix;
    logic [15:0]           count;
    logic                  typed;
    dilated_px_t           typed_px;
  } stim_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [7:0]            s_axis_tdata_i;   // [0] pixel_in, [7:1] zero
  logic                  s_axis_tuser_i;   // [0] operation
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic [7:0]            m_axis_tdata_o;   // [0] pixel_out, [7:1] zero
  logic                  m_axis_tlast_o;   // row_end
  logic                  m_axis_tuser_o;   // [0] image_end

  binary_dilation_3x3_core #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // Predicted copy of the block's state.
  bit          row_old [MAX_W];
  bit          row_new [MAX_W];
  logic [8:0]  win;
  int unsigned in_col, in_row, out_col, out_row;
  int unsigned img_w = 64;
  int unsigned img_h = 64;

  dilated_px_t expected_px[$];
  int unsigned send_idle_pct = 30;
  int unsigned recv_idle_pct = 61;
  int unsigned mismatches, results_checked, images_done, items_sent, cfg_writes;
  int unsigned quiet_cycles, hold_left;
  bit          hold_done;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  task automatic report_mismatch(input string what, input logic [2:0] got,
                                 input logic [2:0] want);
    if (mismatches < MAX_PRINTED)
      $display("%0t: result %0d %s: got %b, want %b", $time, results_checked, what, got, want);
    mismatches++;
  endtask

  function void restart_positions();
    win     = '0;
    in_col  = 0;
    in_row  = 0;
    out_col = 0;
    out_row = 0;
  endfunction

  // Register write: out-of-range sizes clamp, and any size write restarts the stream.
  function void apply_size_write(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] val);
    int unsigned v;
    if (idx == REG_IMAGE_WIDTH) begin
      v = 32'(val[IMAGE_WIDTH_W-1:0]);
      img_w = (v == 0) ? 1 : ((v > MAX_W) ? MAX_W : v);
      restart_positions();
    end else if (idx == REG_IMAGE_HEIGHT) begin
      v = 32'(val[IMAGE_HEIGHT_W-1:0]);
      img_h = (v == 0) ? 1 : ((v > MAX_H) ? MAX_H : v);
      restart_positions();
    end
  endfunction

  // Advance the dilation state by one item; returns 1 when a result pixel falls out.
  function automatic bit predict_dilation(input item_op_e op, input logic pix,
                                          output dilated_px_t res);
    logic        px_eff;
    logic [2:0]  col_vec;
    logic [8:0]  keep;
    bit          emit, last_col, last_px;
    int unsigned col;
    px_eff = (op == OP_PAD) ? 1'b0 : pix;
    col = (in_col < MAX_W) ? in_col : MAX_W - 1;
    col_vec = {px_eff, row_new[col], row_old[col]};
    row_old[col] = row_new[col];
    row_new[col] = px_eff;
    win = {col_vec, win[8:3]};
    emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
    in_col++;
    if (in_col >= img_w) begin
      in_col = 0;
      in_row++;
    end
    res = '0;
    if (!emit) return 1'b0;
    last_col = (out_col + 1 >= img_w);
    last_px  = last_col && (out_row + 1 >= img_h);
    // Neighbors outside the image never count.
    keep = 9'h1FF;
    if (out_col == 0) keep &= ~LEFT_COL;
    if (last_col) keep &= ~RIGHT_COL;
    if (out_row == 0) keep &= ~TOP_ROW;
    if (out_row + 1 >= img_h) keep &= ~BOTTOM_ROW;
    res.pixel     = |(win & keep);
    res.row_end   = last_col;
    res.image_end = last_px;
    if (last_px) begin
      restart_positions();
    end else if (last_col) begin
      out_col = 0;
      out_row++;
    end else begin
      out_col++;
    end
    return 1'b1;
  endfunction

  // Offer one item, sometimes after a random gap; valid stays high into the next item.
  task automatic send_item(input item_op_e op, input logic pix, input logic typed,
                           input dilated_px_t typed_px);
    dilated_px_t res;
    bit          has;
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {7'd0, pix};
    s_axis_tuser_i  <= op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    has = predict_dilation(op, pix, res);
    if (typed) expected_px.push_back(typed_px);
    else if (has) expected_px.push_back(res);
    items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_size_write(idx, val);
    cfg_writes++;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stop offering, wait for every predicted result, then let the pipeline settle.
  task automatic wait_until_drained();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_px.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One image of random content and its drain items, or a cut-off image when broken.
  task automatic send_image(input int unsigned w, input int unsigned h, input bit broken);
    int unsigned n_px, density;
    n_px = w * h;
    if (broken) n_px = $urandom_range(0, n_px - 1);
    case ($urandom_range(4))
      0:       density = 0;
      1:       density = 100;
      default: density = $urandom_range(2, 30);
    endcase
    repeat (n_px)
      send_item(($urandom_range(11) == 0) ? OP_PAD : OP_PIXEL,
                $urandom_range(99) < density, 1'b0, '0);
    // Drain items: pixels here only land in masked positions.
    if (!broken)
      repeat (w + 1)
        send_item(item_op_e'($urandom_range(1)), 1'($urandom_range(1)), 1'b0, '0);
  endtask

  function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] val);
    stim_row_t r;
    r = '0;
    r.is_cfg    = 1'b1;
    r.cfg_index = idx;
    r.cfg_data  = val;
    return r;
  endfunction

  function automatic stim_row_t item_row(input item_op_e op, input logic pix,
                                         input int unsigned n);
    stim_row_t r;
    r = '0;
    r.op    = op;
    r.pix   = pix;
    r.count = 16'(n);
    return r;
  endfunction

  function automatic stim_row_t checked_row(input item_op_e op, input logic pix,
                                            input dilated_px_t px);
    stim_row_t r;
    r = item_row(op, pix, 1);
    r.typed    = 1'b1;
    r.typed_px = px;
    return r;
  endfunction

  // Output side: check each transaction, then pick the next ready value.
  always @(posedge clk_i) begin : rx_side
    dilated_px_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_px.size() == 0) begin
        report_mismatch("arrived with none expected",
                        {m_axis_tdata_o[0], m_axis_tlast_o, m_axis_tuser_o}, 3'bxxx);
      end else begin
        want = expected_px.pop_front();
        if (m_axis_tdata_o[0] !== want.pixel)
          report_mismatch("pixel_out", {2'b00, m_axis_tdata_o[0]}, {2'b00, want.pixel});
        if (m_axis_tlast_o !== want.row_end)
          report_mismatch("row_end", {2'b00, m_axis_tlast_o}, {2'b00, want.row_end});
        if (m_axis_tuser_o !== want.image_end)
          report_mismatch("image_end", {2'b00, m_axis_tuser_o}, {2'b00, want.image_end});
      end
      results_checked++;
      if (m_axis_tuser_o === 1'b1) images_done++;
    end
    // One long hold-off so the block fills up and stalls its input.
    if (hold_left != 0) begin
      m_axis_tready_i <= 1'b0;
      hold_left--;
    end else if (!hold_done && results_checked >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: ends the run when no transaction happens for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i) || (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, expected_px.size());
      $display("binary_dilation_3x3_core verification failed");
      $finish;
    end
  end

  // Stimulus: directed rows, then random images in three idling sections.
  initial begin : stimulus
    stim_row_t   directed[$];
    stim_row_t   row;
    int unsigned rand_start, done_rand;
    bit          wide_done, tall_done;

    rst_ni          <= 1'b0;
    cfg_valid_i     <= 1'b0;
    cfg_index_i     <= REG_IMAGE_WIDTH;
    cfg_data_i      <= '0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= OP_PIXEL;
    m_axis_tready_i <= 1'b0;
    restart_positions();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset size 64x64: first result comes after one row and one pixel.
    directed.push_back(item_row(OP_PIXEL, 1'b1, 64));
    directed.push_back(item_row(OP_PAD, 1'b0, 1));
    directed.push_back(checked_row(OP_PAD, 1'b0, BLACK_INTERIOR));
    // Zero sizes clamp to a 1x1 image.
    directed.push_back(cfg_row(REG_IMAGE_WIDTH, 13'd0));
    directed.push_back(cfg_row(REG_IMAGE_HEIGHT, 13'd0));
    directed.push_back(item_row(OP_PIXEL, 1'b1, 1));
    directed.push_back(item_row(OP_PAD, 1'b0, 1));
    directed.push_back(checked_row(OP_PAD, 1'b0, BLACK_LAST));
    directed.push_back(item_row(OP_PIXEL, 1'b0, 1));
    directed.push_back(item_row(OP_PAD, 1'b1, 1));
    directed.push_back(checked_row(OP_PAD, 1'b1, WHITE_LAST));
    // A padding item inside the image is white whatever its pixel bit.
    directed.push_back(item_row(OP_PAD, 1'b1, 1));
    directed.push_back(item_row(OP_PAD, 1'b1, 1));
    directed.push_back(checked_row(OP_PIXEL, 1'b1, WHITE_LAST));
    // Writes to undecoded indexes leave the 1x1 size in place.
    directed.push_back(cfg_row(REG_SPARE_2, 13'h1FFF));
    directed.push_back(cfg_row(REG_SPARE_3, 13'h0AAA));
    directed.push_back(item_row(OP_PIXEL, 1'b1, 1));
    directed.push_back(item_row(OP_PIXEL, 1'b0, 1));
    directed.push_back(checked_row(OP_PIXEL, 1'b0, BLACK_LAST));
    // 3x3 with only the center black, then only a corner; width bits above 10 drop.
    directed.push_back(cfg_row(REG_IMAGE_WIDTH, 13'h1803));
    directed.push_back(cfg_row(REG_IMAGE_HEIGHT, 13'd3));
    directed.push_back(item_row(OP_PIXEL, 1'b0, 4));
    directed.push_back(item_row(OP_PIXEL, 1'b1, 1));
    directed.push_back(item_row(OP_PIXEL, 1'b0, 4));
    directed.push_back(item_row(OP_PAD, 1'b0, 4));
    directed.push_back(item_row(OP_PIXEL, 1'b1, 1));
    directed.push_back(item_row(OP_PIXEL, 1'b0, 8));
    directed.push_back(item_row(OP_PAD, 1'b1, 4));

    foreach (directed[i]) begin
      row = directed[i];
      if (row.is_cfg) begin
        wait_until_drained();
        write_reg(row.cfg_index, row.cfg_data);
      end else begin
        repeat (row.count) send_item(row.op, row.pix, row.typed, row.typed_px);
      end
    end

    // Random images; the two largest sizes each get one short cut-off run.
    rand_start = items_sent;
    wide_done  = 1'b0;
    tall_done  = 1'b0;
    done_rand  = 0;
    while (done_rand < RANDOM_ITEMS) begin
      if (done_rand < RANDOM_ITEMS / 3) begin
        send_idle_pct = 30;
        recv_idle_pct = 61;
      end else if (done_rand < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 61;
        recv_idle_pct = 30;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      if (!wide_done && done_rand >= RANDOM_ITEMS / 3) begin
        wide_done = 1'b1;
        wait_until_drained();
        write_reg(REG_IMAGE_WIDTH, 13'h07FF);
        write_reg(REG_IMAGE_HEIGHT, 13'd2);
        repeat (BIG_RUN) send_item(OP_PIXEL, 1'($urandom_range(1)), 1'b0, '0);
        wait_until_drained();
        write_reg(REG_IMAGE_WIDTH, 13'd8);
        write_reg(REG_IMAGE_HEIGHT, 13'd8);
      end
      if (!tall_done && done_rand >= 2 * RANDOM_ITEMS / 3) begin
        tall_done = 1'b1;
        wait_until_drained();
        write_reg(REG_IMAGE_WIDTH, 13'd1);
        write_reg(REG_IMAGE_HEIGHT, 13'h1FFF);
        repeat (BIG_RUN) send_item(OP_PIXEL, 1'($urandom_range(1)), 1'b0, '0);
        wait_until_drained();
        write_reg(REG_IMAGE_WIDTH, 13'd8);
        write_reg(REG_IMAGE_HEIGHT, 13'd8);
      end

      // Small sizes; either register is sometimes left as it was.
      wait_until_drained();
      if ($urandom_range(3) != 0)
        write_reg(REG_IMAGE_WIDTH, ($urandom_range(9) == 0) ? '0 :
                  CFG_DATA_W'($urandom_range(1, ($urandom_range(3) == 0) ? 24 : 8)));
      if ($urandom_range(3) != 0)
        write_reg(REG_IMAGE_HEIGHT, ($urandom_range(9) == 0) ? '0 :
                  CFG_DATA_W'($urandom_range(1, 10)));
      if ($urandom_range(7) == 0)
        write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3,
                  CFG_DATA_W'($urandom_range(8191)));
      repeat ($urandom_range(1, 3)) send_image(img_w, img_h, $urandom_range(5) == 0);
      // Stray items that start the next image early.
      if ($urandom_range(4) == 0)
        repeat ($urandom_range(1, 5))
          send_item(item_op_e'($urandom_range(1)), 1'($urandom_range(1)), 1'b0, '0);
      done_rand = items_sent - rand_start;
    end

    wait_until_drained();
    $display("Sent %0d items through %0d register writes, with cut-off runs at the largest sizes.",
             items_sent, cfg_writes);
    $display("Checked %0d result pixels across %0d finished images, %0d mismatches.",
             results_checked, images_done, mismatches);
    if (mismatches == 0)
      $display("binary_dilation_3x3_core verification clean");
    else
      $display("binary_dilation_3x3_core verification failed");
    $finish;
  end

endmodule
